// File: hw/rtl/ssah_pkg.sv
// Shared types, request and status codes for the sampled history table.
package ssah_pkg;

  localparam int KEY_W    = 64;
  localparam int LIMIT_W  = 13;
  localparam int PERIOD_W = 8;
  localparam int COUNT_W  = 13;

  localparam logic [63:0] GOLDEN = 64'h61C8864680B583EB;
  localparam logic [LIMIT_W-1:0] MIN_LIMIT = 13'd1024;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd8;

  localparam logic [0:0] CFG_CAPACITY_LIMIT = 1'b0;
  localparam logic [0:0] CFG_SAMPLE_PERIOD  = 1'b1;

  localparam logic [2:0] REQ_RECORD = 3'd0;
  localparam logic [2:0] REQ_LOOKUP = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_SHRINK = 3'd4;

  localparam logic [2:0] ST_SKIPPED   = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_EVICTED   = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;
  localparam logic [2:0] ST_BULK_DONE = 3'd6;

  typedef struct packed {
    logic [KEY_W-1:0] owner;
    logic [KEY_W-1:0] page;
    logic [KEY_W-1:0] seq;
  } entry_t;

endpackage

// File: hw/rtl/ssah_hash.sv
// Iterative golden-ratio hash: one 32x32 multiplier and a 64-bit accumulator.
module ssah_hash #(
  parameter int SET_INDEX_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [63:0]               operand,
  output logic                      done,
  output logic [SET_INDEX_BITS-1:0] result
);

  logic [63:0] a;
  logic [63:0] acc;
  logic [63:0] prod;
  logic [1:0]  step;
  logic        run;
  logic        add_phase;
  logic [31:0] mul_a;
  logic [31:0] mul_b;

  assign mul_a  = (step == 2'd1) ? a[63:32] : a[31:0];
  assign mul_b  = (step == 2'd2) ? ssah_pkg::GOLDEN[63:32] : ssah_pkg::GOLDEN[31:0];
  assign result = acc[63:64-SET_INDEX_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      run       <= 1'b0;
      done      <= 1'b0;
      add_phase <= 1'b0;
      step      <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run       <= 1'b1;
        add_phase <= 1'b0;
        step      <= 2'd0;
      end else if (run) begin
        if (!add_phase) begin
          add_phase <= 1'b1;
        end else begin
          add_phase <= 1'b0;
          if (step == 2'd2) begin
            run  <= 1'b0;
            done <= 1'b1;
          end else begin
            step <= step + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a   <= operand;
      acc <= 64'd0;
    end else if (run) begin
      if (!add_phase) begin
        prod <= 64'(mul_a) * 64'(mul_b);
      end else if (step == 2'd0) begin
        acc <= acc + prod;
      end else begin
        acc <= acc + {prod[31:0], 32'd0};
      end
    end
  end

endmodule

// File: hw/rtl/sampled_set_assoc_history_table.sv
// A skipped record or an unused code goes straight to the output state, which
// registers its result word. A keyed request runs three iterative hashes, then
// a set read, the set update and the result register. Shrink and clear read
// and rewrite the metadata of each set visited. One request at a time; the
// result register lets the next word enter early.
// Reset runs a clearing pass over the set metadata while requests stall.
module sampled_set_assoc_history_table #(
  parameter int SET_INDEX_BITS = 10,
  parameter int WAYS           = 4,
  parameter int SHRINK_BATCH   = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [63:0] owner_key,
  input  logic [63:0] page_index,
  input  logic [63:0] new_seq,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        hit,
  output logic [63:0] seq_out,
  output logic [2:0]  status,
  output logic [12:0] removed_count,
  output logic [12:0] live_count,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  localparam int NSETS = 1 << SET_INDEX_BITS;
  localparam int WIDX  = $clog2(WAYS);
  localparam int NW    = $clog2(WAYS + 1);
  localparam int CNT_W = SET_INDEX_BITS + WIDX + 1;
  localparam int TOTAL = NSETS * WAYS;
  localparam int SHR   = (SHRINK_BATCH > TOTAL) ? TOTAL : SHRINK_BATCH;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_BULK_RD = 4'd2;
  localparam logic [3:0] S_BULK_WR = 4'd3;
  localparam logic [3:0] S_HA      = 4'd4;
  localparam logic [3:0] S_HAW     = 4'd5;
  localparam logic [3:0] S_HB      = 4'd6;
  localparam logic [3:0] S_HBW     = 4'd7;
  localparam logic [3:0] S_HC      = 4'd8;
  localparam logic [3:0] S_HCW     = 4'd9;
  localparam logic [3:0] S_RD      = 4'd10;
  localparam logic [3:0] S_EVAL    = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  typedef struct packed {
    logic [NW-1:0]                fill;
    logic [WAYS-1:0][WIDX-1:0]    order;
  } meta_t;

  typedef ssah_pkg::entry_t [WAYS-1:0] row_t;

  meta_t meta_mem [NSETS];
  row_t  row_mem  [NSETS];

  logic [3:0] state;
  logic [ssah_pkg::LIMIT_W-1:0]  capacity_limit;
  logic [ssah_pkg::PERIOD_W-1:0] sample_period;
  logic [ssah_pkg::PERIOD_W-1:0] sample_phase;
  logic [CNT_W-1:0] live;
  logic [CNT_W-1:0] bulk_cnt;
  logic [CNT_W-1:0] bulk_lim;
  logic [SET_INDEX_BITS:0] bulk_set;
  logic [SET_INDEX_BITS-1:0] init_ptr;
  logic [SET_INDEX_BITS-1:0] set_idx;
  logic [SET_INDEX_BITS-1:0] hx;
  logic [SET_INDEX_BITS-1:0] hy;
  logic [2:0]  req_q;
  logic [63:0] owner_q;
  logic [63:0] page_q;
  logic [63:0] seq_q;
  logic        res_hit;
  logic [63:0] res_seq;
  logic [2:0]  res_status;

  logic [SET_INDEX_BITS-1:0] rd_addr;
  logic [SET_INDEX_BITS-1:0] wr_addr;
  logic  meta_we;
  logic  row_we;
  meta_t meta_wd;
  row_t  row_wd;
  meta_t meta_rd;
  row_t  row_rd;

  logic        hash_start;
  logic [63:0] hash_operand;
  logic        hash_done;
  logic [SET_INDEX_BITS-1:0] hash_result;

  logic [ssah_pkg::LIMIT_W-1:0] lim_eff;
  logic [14:0] thr;
  logic [ssah_pkg::PERIOD_W-1:0] per;
  logic [8:0]  ph;

  ssah_hash #(.SET_INDEX_BITS(SET_INDEX_BITS)) u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (hash_start),
    .operand (hash_operand),
    .done    (hash_done),
    .result  (hash_result)
  );

  assign lim_eff = (capacity_limit < ssah_pkg::MIN_LIMIT) ? ssah_pkg::MIN_LIMIT
                                                          : capacity_limit;
  assign thr     = 15'((17'(lim_eff) * 17'd3) >> 2);
  assign per     = (sample_period == '0) ? 8'd1 : sample_period;
  assign ph      = 9'(sample_phase) + 9'd1;

  assign hash_start = (state == S_HA) || (state == S_HB) || (state == S_HC);
  always_comb begin
    unique case (state)
      S_HA:    hash_operand = owner_q;
      S_HB:    hash_operand = page_q;
      default: hash_operand = 64'(hx ^ hy);
    endcase
  end

  assign rd_addr = (state == S_BULK_RD) ? bulk_set[SET_INDEX_BITS-1:0] : set_idx;

  // bulk removal of one set: drop the k newest
  logic [NW-1:0]  bk;
  logic [CNT_W-1:0] brem;
  meta_t bulk_meta;
  always_comb begin
    brem = bulk_lim - bulk_cnt;
    bk   = (brem < CNT_W'(meta_rd.fill)) ? NW'(brem) : meta_rd.fill;
    bulk_meta.fill  = meta_rd.fill - bk;
    bulk_meta.order = '0;
    for (int p = 0; p < WAYS; p++) begin
      if (p + int'(bk) < WAYS) begin
        bulk_meta.order[p] = meta_rd.order[p + int'(bk)];
      end
    end
  end

  // set update for keyed requests
  logic [WAYS-1:0] vld;
  logic [WAYS-1:0] vld2;
  logic [WAYS-1:0] match;
  logic            e_hit;
  logic [WIDX-1:0] hw;
  logic [WIDX-1:0] hp;
  logic [WIDX-1:0] fw;
  logic            evict;
  meta_t           e_meta;
  row_t            e_row;
  always_comb begin
    vld = '0;
    for (int p = 0; p < WAYS; p++) begin
      if (p < int'(meta_rd.fill)) vld[meta_rd.order[p]] = 1'b1;
    end
    for (int w = 0; w < WAYS; w++) begin
      match[w] = vld[w] && (row_rd[w].owner == owner_q) && (row_rd[w].page == page_q);
    end
    e_hit = |match;
    hw = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (match[w]) hw = WIDX'(w);
    end
    hp = '0;
    for (int p = 0; p < WAYS; p++) begin
      if (p < int'(meta_rd.fill) && meta_rd.order[p] == hw) hp = WIDX'(p);
    end
    evict = (int'(meta_rd.fill) >= WAYS);
    vld2  = vld;
    if (evict) vld2[meta_rd.order[WAYS-1]] = 1'b0;
    fw = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!vld2[w]) fw = WIDX'(w);
    end
    e_meta = meta_rd;
    e_row  = row_rd;
    if (req_q == ssah_pkg::REQ_RECORD) begin
      if (e_hit) begin
        e_row[hw].seq = seq_q;
      end else begin
        e_meta.order[0] = fw;
        for (int p = 1; p < WAYS; p++) e_meta.order[p] = meta_rd.order[p-1];
        e_meta.fill = evict ? meta_rd.fill : meta_rd.fill + NW'(1);
        e_row[fw].owner = owner_q;
        e_row[fw].page  = page_q;
        e_row[fw].seq   = seq_q;
      end
    end else if (req_q == ssah_pkg::REQ_REMOVE && e_hit) begin
      for (int p = 0; p < WAYS - 1; p++) begin
        if (p >= int'(hp)) e_meta.order[p] = meta_rd.order[p+1];
      end
      e_meta.fill = meta_rd.fill - NW'(1);
    end
  end

  always_comb begin
    meta_we = 1'b0;
    row_we  = 1'b0;
    wr_addr = set_idx;
    meta_wd = e_meta;
    row_wd  = e_row;
    unique case (state)
      S_INIT: begin
        meta_we = 1'b1;
        wr_addr = init_ptr;
        meta_wd = '0;
      end
      S_BULK_WR: begin
        meta_we = 1'b1;
        wr_addr = bulk_set[SET_INDEX_BITS-1:0];
        meta_wd = bulk_meta;
      end
      S_EVAL: begin
        meta_we = 1'b1;
        row_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[wr_addr] <= meta_wd;
    if (row_we) row_mem[wr_addr] <= row_wd;
    meta_rd <= meta_mem[rd_addr];
    row_rd  <= row_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= ssah_pkg::LIMIT_RESET;
      sample_period  <= ssah_pkg::PERIOD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == ssah_pkg::CFG_CAPACITY_LIMIT) capacity_limit <= cfg_data;
      else sample_period <= cfg_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_INIT;
      init_ptr     <= '0;
      live         <= '0;
      sample_phase <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_OUT) rsp_valid <= 1'b0;
      unique case (state)
        S_INIT: begin
          init_ptr <= init_ptr + SET_INDEX_BITS'(1);
          if (init_ptr == SET_INDEX_BITS'(NSETS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req_valid) begin
            req_q      <= req_type;
            owner_q    <= owner_key;
            page_q     <= page_index;
            seq_q      <= new_seq;
            res_hit    <= 1'b0;
            res_seq    <= '0;
            res_status <= (req_type == ssah_pkg::REQ_CLEAR ||
                           req_type == ssah_pkg::REQ_SHRINK) ? ssah_pkg::ST_BULK_DONE
                                                             : ssah_pkg::ST_SKIPPED;
            bulk_cnt   <= '0;
            bulk_set   <= '0;
            unique case (req_type) inside
              ssah_pkg::REQ_RECORD: begin
                if (ph < 9'(per)) begin
                  sample_phase <= ph[7:0];
                  state        <= S_OUT;
                end else begin
                  sample_phase <= '0;
                  bulk_lim     <= CNT_W'(SHR);
                  if (32'(live) >= 32'(thr)) state <= S_BULK_RD;
                  else state <= S_HA;
                end
              end
              ssah_pkg::REQ_LOOKUP, ssah_pkg::REQ_REMOVE: state <= S_HA;
              ssah_pkg::REQ_CLEAR: begin
                bulk_lim   <= CNT_W'(TOTAL);
                state      <= S_BULK_RD;
              end
              ssah_pkg::REQ_SHRINK: begin
                bulk_lim   <= CNT_W'(SHR);
                state      <= S_BULK_RD;
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_BULK_RD: begin
          if (bulk_set[SET_INDEX_BITS] || bulk_cnt >= bulk_lim) begin
            state <= (req_q == ssah_pkg::REQ_RECORD) ? S_HA : S_OUT;
          end else begin
            state <= S_BULK_WR;
          end
        end
        S_BULK_WR: begin
          live     <= (live > CNT_W'(bk)) ? live - CNT_W'(bk) : '0;
          bulk_cnt <= bulk_cnt + CNT_W'(bk);
          bulk_set <= bulk_set + {{SET_INDEX_BITS{1'b0}}, 1'b1};
          state    <= S_BULK_RD;
        end
        S_HA: state <= S_HAW;
        S_HAW: begin
          if (hash_done) begin
            hx    <= hash_result;
            state <= S_HB;
          end
        end
        S_HB: state <= S_HBW;
        S_HBW: begin
          if (hash_done) begin
            hy    <= hash_result;
            state <= S_HC;
          end
        end
        S_HC: state <= S_HCW;
        S_HCW: begin
          if (hash_done) begin
            set_idx <= hash_result;
            state   <= S_RD;
          end
        end
        S_RD: state <= S_EVAL;
        S_EVAL: begin
          res_hit <= e_hit;
          res_seq <= e_hit ? row_rd[hw].seq : 64'd0;
          if (req_q == ssah_pkg::REQ_RECORD) begin
            if (e_hit) begin
              res_status <= ssah_pkg::ST_UPDATED;
            end else if (evict) begin
              res_status <= ssah_pkg::ST_EVICTED;
            end else begin
              res_status <= ssah_pkg::ST_INSERTED;
              live       <= live + CNT_W'(1);
            end
          end else begin
            res_status <= e_hit ? ssah_pkg::ST_FOUND : ssah_pkg::ST_NOT_FOUND;
            if (req_q == ssah_pkg::REQ_REMOVE && e_hit && live != '0) begin
              live <= live - CNT_W'(1);
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!rsp_valid || !rsp_stall)) begin
      hit           <= res_hit;
      seq_out       <= res_seq;
      status        <= res_status;
      removed_count <= 13'(bulk_cnt);
      live_count    <= 13'(live);
    end
  end

  assign req_stall = (state != S_IDLE);

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    32'(live) <= TOTAL)
    else $error("live count above table size");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL || state == S_BULK_WR) |-> 32'(meta_rd.fill) <= WAYS)
    else $error("set fill above way count");

  a_hash_owner: assert property (@(posedge clk) disable iff (rst)
    hash_done |-> (state == S_HAW || state == S_HBW || state == S_HCW))
    else $error("hash result with no waiting step");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (state != S_IDLE))
    else $error("accepted word left no work");

  a_bulk_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_BULK_RD) |-> bulk_cnt <= bulk_lim)
    else $error("bulk removal passed its limit");

endmodule
